// File: design/stlc_pkg.sv
// Package for the stepper travel learning controller.
// Holds the request and result types, the code constants and the phase table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stlc_pkg;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_BUTTON = 2'd1;
  localparam logic [1:0] ACT_CMD    = 2'd2;

  localparam logic [3:0] CMD_STOP    = 4'd0;
  localparam logic [3:0] CMD_FORWARD = 4'd1;
  localparam logic [3:0] CMD_REVERSE = 4'd2;
  localparam logic [3:0] CMD_SWEEP   = 4'd3;

  localparam logic [1:0] MODE_STOP    = 2'd0;
  localparam logic [1:0] MODE_FORWARD = 2'd1;
  localparam logic [1:0] MODE_REVERSE = 2'd2;
  localparam logic [1:0] MODE_SWEEP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CMD  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_FIRST  = 2'd1;
  localparam logic [1:0] BTN_SECOND = 2'd2;

  localparam logic [15:0] DEFAULT_TRAVEL = 16'd1000;
  localparam logic [9:0]  PCT_FULL       = 10'd100;
  localparam logic [15:0] STEP_SAT       = 16'd32767;

  // Percent factors are scaled by 2^FACTOR_SHIFT; the reciprocal of 100 is
  // first formed at 2^36 and then rounded up to that scale.
  localparam int          FACTOR_SHIFT = 29;
  localparam logic [29:0] RECIP_100_36 = 30'd687194768;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] button_levels;
    logic [3:0] command_code;
    logic [9:0] percent_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  coil_pattern;
    logic [1:0]  motor_mode;
    logic        running_flag;
    logic [1:0]  status;
    logic [31:0] steps_done;
    logic [31:0] learned_steps;
  } out_item_t;

  function automatic logic [3:0] coil_of(input logic [2:0] phase);
    logic [3:0] pattern;
    case (phase)
      3'd0: pattern = 4'b0001;
      3'd1: pattern = 4'b0011;
      3'd2: pattern = 4'b0010;
      3'd3: pattern = 4'b0110;
      3'd4: pattern = 4'b0100;
      3'd5: pattern = 4'b1100;
      3'd6: pattern = 4'b1000;
      3'd7: pattern = 4'b1001;
      default: pattern = 4'b0000;
    endcase
    return pattern;
  endfunction

endpackage

`default_nettype wire

// File: design/stlc_if.sv
// Request and result channels of the stepper travel learning controller.
// Each carries valid, ready and a payload struct from stlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stlc_in_if;
  logic               valid;
  logic               ready;
  stlc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stlc_out_if;
  logic                valid;
  logic                ready;
  stlc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/stlc_budget.sv
// Step budget unit: travel times a scaled percent factor that holds the division
// by 100, saturated to the step limit and held at one step minimum. Uses stlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stlc_budget (
  input  wire logic [31:0] travel_i,
  input  wire logic [29:0] factor_i,
  output logic      [15:0] steps_o
);
  import stlc_pkg::*;

  logic [61:0] product;
  logic [32:0] quotient;

  assign product  = {30'd0, travel_i} * {32'd0, factor_i};
  assign quotient = product[61:FACTOR_SHIFT];

  always_comb begin
    if (quotient > {17'd0, STEP_SAT}) begin
      steps_o = STEP_SAT;
    end else if (quotient == 33'd0) begin
      steps_o = 16'd1;
    end else begin
      steps_o = quotient[15:0];
    end
  end

endmodule

`default_nettype wire

// File: design/stepper_travel_learning_controller_top.sv
// Top level of the stepper travel learning controller.
// Depends on stlc_pkg, the channel interfaces in stlc_if and stlc_budget.
//
//   Channel   Direction   Payload
//   in_i      sink        action, button_levels, command_code, percent_value
//   out_o     source      coil_pattern, motor_mode, running_flag, status,
//                         steps_done, learned_steps
//
// Every request gives one result. A request is held in the input register
// with its percent factor, formed on the way in, and is then resolved against
// the motor state into the result register; one request per cycle while out_o does not stall.
// Reset returns the motor state to stopped with the default travel loaded.
// A stalled result holds the result register, and the input register keeps
// taking requests until it is full as well.
`timescale 1ns / 1ps
`default_nettype none

module stepper_travel_learning_controller_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stlc_in_if.sink    in_i,
  stlc_out_if.source out_o
);
  import stlc_pkg::*;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic [29:0] factor_q, factor_d;
  logic        pct_over_q;
  logic        advance;

  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] steps_left_q, steps_left_d;
  logic [15:0] default_travel_q, default_travel_d;
  logic        dir_q, dir_d;
  logic        running_q, running_d;
  logic [31:0] step_count_q, step_count_d;
  logic [31:0] learned_q, learned_d;
  logic [1:0]  last_button_q, last_button_d;
  logic [3:0]  coil_q, coil_d;

  logic [6:0]  pct_eff;
  logic [36:0] pct_scaled;
  logic        learned_path;
  logic [31:0] travel;
  logic [15:0] budget;
  logic [1:0]  pressed;
  logic [1:0]  status;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_comb begin
    if (in_i.data.command_code == CMD_SWEEP ||
        in_i.data.percent_value > PCT_FULL) begin
      pct_eff = PCT_FULL[6:0];
    end else begin
      pct_eff = in_i.data.percent_value[6:0];
    end
    pct_scaled = {30'd0, pct_eff} * {7'd0, RECIP_100_36};
    factor_d   = 30'((pct_scaled + 37'd127) >> 7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q  <= in_i.data;
      factor_q   <= factor_d;
      pct_over_q <= (in_i.data.command_code != CMD_SWEEP) &&
                    (in_i.data.percent_value > PCT_FULL);
    end
  end

  assign learned_path = !running_q && (learned_q != 32'd0);
  assign travel       = learned_path ? learned_q : {16'd0, default_travel_q};

  stlc_budget u_budget (
    .travel_i (travel),
    .factor_i (factor_q),
    .steps_o  (budget)
  );

  always_comb begin
    phase_d          = phase_q;
    mode_d           = mode_q;
    steps_left_d     = steps_left_q;
    default_travel_d = default_travel_q;
    dir_d            = dir_q;
    running_d        = running_q;
    step_count_d     = step_count_q;
    learned_d        = learned_q;
    last_button_d    = last_button_q;
    coil_d           = coil_q;
    status           = ST_OK;
    pressed          = BTN_NONE;

    case (in_item_q.action)
      ACT_TICK: begin
        if (mode_q inside {MODE_FORWARD, MODE_REVERSE}) begin
          if (steps_left_q != 16'd0) begin
            phase_d      = (mode_q == MODE_FORWARD) ? phase_q + 3'd1 : phase_q - 3'd1;
            coil_d       = coil_of(phase_d);
            step_count_d = step_count_q + 32'd1;
            if (!steps_left_q[15]) begin
              steps_left_d = steps_left_q - 16'd1;
            end
          end else begin
            mode_d    = MODE_STOP;
            running_d = 1'b0;
            coil_d    = 4'd0;
          end
        end else if (mode_q == MODE_SWEEP) begin
          if (in_item_q.button_levels != 2'b00) begin
            dir_d = !dir_q;
          end
          phase_d          = !dir_d ? phase_q + 3'd1 : phase_q - 3'd1;
          coil_d           = coil_of(phase_d);
          default_travel_d = default_travel_q + 16'd1;
        end else begin
          coil_d = 4'd0;
        end
      end
      ACT_BUTTON: begin
        if (!in_item_q.button_levels[0]) begin
          pressed = BTN_FIRST;
        end else if (!in_item_q.button_levels[1]) begin
          pressed = BTN_SECOND;
        end
        if (pressed != BTN_NONE) begin
          if (!running_q) begin
            dir_d         = !dir_q;
            running_d     = 1'b1;
            step_count_d  = 32'd0;
            last_button_d = pressed;
            mode_d        = dir_d ? MODE_REVERSE : MODE_FORWARD;
            steps_left_d  = 16'hFFFF;
          end else if (pressed != last_button_q) begin
            mode_d        = MODE_STOP;
            steps_left_d  = 16'd0;
            running_d     = 1'b0;
            coil_d        = 4'd0;
            learned_d     = step_count_q;
            last_button_d = BTN_NONE;
          end
        end
      end
      ACT_CMD: begin
        if (learned_path) begin
          if (!pct_over_q &&
              (in_item_q.command_code inside {CMD_FORWARD, CMD_REVERSE, CMD_SWEEP})) begin
            steps_left_d = budget;
            mode_d       = in_item_q.command_code[1:0];
            running_d    = 1'b1;
            learned_d    = 32'd0;
          end else begin
            status = ST_REJECTED;
          end
        end else begin
          case (in_item_q.command_code)
            CMD_FORWARD, CMD_REVERSE: begin
              steps_left_d = budget;
              mode_d       = in_item_q.command_code[1:0];
              running_d    = 1'b1;
              step_count_d = 32'd0;
            end
            CMD_SWEEP: begin
              dir_d            = 1'b0;
              mode_d           = MODE_SWEEP;
              default_travel_d = 16'd0;
              running_d        = 1'b1;
              step_count_d     = 32'd0;
            end
            default: begin
              mode_d       = MODE_STOP;
              steps_left_d = 16'd0;
              running_d    = 1'b0;
              coil_d       = 4'd0;
              if (in_item_q.command_code != CMD_STOP) begin
                status = ST_BAD_CMD;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    out_item_d.coil_pattern  = coil_d;
    out_item_d.motor_mode    = mode_d;
    out_item_d.running_flag  = running_d;
    out_item_d.status        = status;
    out_item_d.steps_done    = step_count_d;
    out_item_d.learned_steps = learned_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= 3'd0;
      mode_q           <= MODE_STOP;
      steps_left_q     <= 16'd0;
      default_travel_q <= DEFAULT_TRAVEL;
      dir_q            <= 1'b0;
      running_q        <= 1'b0;
      step_count_q     <= 32'd0;
      learned_q        <= 32'd0;
      last_button_q    <= BTN_NONE;
      coil_q           <= 4'd0;
      out_valid_q      <= 1'b0;
    end else begin
      if (advance) begin
        phase_q          <= phase_d;
        mode_q           <= mode_d;
        steps_left_q     <= steps_left_d;
        default_travel_q <= default_travel_d;
        dir_q            <= dir_d;
        running_q        <= running_d;
        step_count_q     <= step_count_d;
        learned_q        <= learned_d;
        last_button_q    <= last_button_d;
        coil_q           <= coil_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  a_mode_tracks_running: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_STOP) == running_q
  ) else $error("motor mode and running flag disagree");

  a_coils_off_when_stopped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (coil_q != 4'd0) |-> running_q
  ) else $error("coils driven while the motor is stopped");

  a_bounded_step_counts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.action == ACT_TICK && steps_left_q != 16'd0 &&
     (mode_q == MODE_FORWARD || mode_q == MODE_REVERSE))
    |=> (step_count_q == $past(step_count_q) + 32'd1)
  ) else $error("step taken without counting it");

endmodule

`default_nettype wire

// File: test/stlc_motor_checker.sv
// Result checker for the stepper travel learning controller.
// Watches the request and result channels, predicts each result and compares it.
// Depends on stlc_pkg and the channel interfaces in stlc_if.
`timescale 1ns / 1ps

module stlc_motor_checker
  import stlc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  stlc_in_if   req_mon_i,
  stlc_out_if  rsp_mon_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [31:0] HALF_STEP_SEQ = {4'b1001, 4'b1000, 4'b1100, 4'b0100,
                                           4'b0110, 4'b0010, 4'b0011, 4'b0001};
  localparam int REPORT_LIMIT = 10;

  logic [2:0]  phase;
  logic [1:0]  motor_mode;
  logic [15:0] steps_to_go;
  logic [15:0] base_travel;
  logic        reverse_dir;
  logic        motor_on;
  logic [31:0] step_tally;
  logic [31:0] learned_travel;
  logic [1:0]  held_button;
  logic [3:0]  coil_drive;

  out_item_t   motor_status_q[$];
  out_item_t   due_status;
  int          fails;

  function automatic void reset_motor();
    phase          = '0;
    motor_mode     = MODE_STOP;
    steps_to_go    = '0;
    base_travel    = DEFAULT_TRAVEL;
    reverse_dir    = 1'b0;
    motor_on       = 1'b0;
    step_tally     = '0;
    learned_travel = '0;
    held_button    = BTN_NONE;
    coil_drive     = '0;
  endfunction

  function automatic void stop_motor();
    motor_mode  = MODE_STOP;
    steps_to_go = '0;
    motor_on    = 1'b0;
    coil_drive  = '0;
  endfunction

  function automatic void step_phase(input logic fwd);
    phase      = phase + (fwd ? 3'd1 : 3'd7);
    coil_drive = HALF_STEP_SEQ[phase*4 +: 4];
  endfunction

  function automatic logic [15:0] step_budget(input logic [31:0] travel,
                                              input logic [9:0] pct);
    logic [63:0] steps;
    steps = (64'(travel) * 64'(pct)) / 64'(PCT_FULL);
    if (steps > 64'(STEP_SAT)) steps = 64'(STEP_SAT);
    if (steps == '0) steps = 64'd1;
    return steps[15:0];
  endfunction

  function automatic out_item_t next_motor_status(input in_item_t req);
    logic [1:0] verdict;
    logic [1:0] pressed;
    logic [9:0] pct;
    out_item_t  report;
    verdict = ST_OK;
    case (req.action)
      ACT_TICK: begin
        if (motor_mode == MODE_FORWARD || motor_mode == MODE_REVERSE) begin
          if (steps_to_go != '0) begin
            step_phase(motor_mode == MODE_FORWARD);
            step_tally = step_tally + 32'd1;
            if (!steps_to_go[15]) steps_to_go = steps_to_go - 16'd1;
          end else begin
            motor_mode = MODE_STOP;
            motor_on   = 1'b0;
            coil_drive = '0;
          end
        end else if (motor_mode == MODE_SWEEP) begin
          if (|req.button_levels) reverse_dir = ~reverse_dir;
          step_phase(!reverse_dir);
          base_travel = base_travel + 16'd1;
        end else begin
          coil_drive = '0;
        end
      end
      ACT_BUTTON: begin
        if (!req.button_levels[0]) pressed = BTN_FIRST;
        else if (!req.button_levels[1]) pressed = BTN_SECOND;
        else pressed = BTN_NONE;
        if (pressed != BTN_NONE) begin
          if (!motor_on) begin
            reverse_dir = ~reverse_dir;
            motor_on    = 1'b1;
            step_tally  = '0;
            held_button = pressed;
            motor_mode  = reverse_dir ? MODE_REVERSE : MODE_FORWARD;
            steps_to_go = '1;
          end else if (pressed != held_button) begin
            stop_motor();
            learned_travel = step_tally;
            held_button    = BTN_NONE;
          end
        end
      end
      ACT_CMD: begin
        pct = (req.command_code == CMD_SWEEP) ? PCT_FULL : req.percent_value;
        if (!motor_on && learned_travel != '0) begin
          if (pct <= PCT_FULL && req.command_code >= CMD_FORWARD &&
              req.command_code <= CMD_SWEEP) begin
            steps_to_go    = step_budget(learned_travel, pct);
            motor_mode     = req.command_code[1:0];
            motor_on       = 1'b1;
            learned_travel = '0;
          end else begin
            verdict = ST_REJECTED;
          end
        end else if (req.command_code == CMD_FORWARD || req.command_code == CMD_REVERSE) begin
          if (pct > PCT_FULL) pct = PCT_FULL;
          steps_to_go = step_budget({16'd0, base_travel}, pct);
          motor_mode  = req.command_code[1:0];
          motor_on    = 1'b1;
          step_tally  = '0;
        end else if (req.command_code == CMD_STOP) begin
          stop_motor();
        end else if (req.command_code == CMD_SWEEP) begin
          reverse_dir = 1'b0;
          motor_mode  = MODE_SWEEP;
          base_travel = '0;
          motor_on    = 1'b1;
          step_tally  = '0;
        end else begin
          stop_motor();
          verdict = ST_BAD_CMD;
        end
      end
      default: ;
    endcase
    report.coil_pattern  = coil_drive;
    report.motor_mode    = motor_mode;
    report.running_flag  = motor_on;
    report.status        = verdict;
    report.steps_done    = step_tally;
    report.learned_steps = learned_travel;
    return report;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] got,
                                      input logic [31:0] want);
    if (got !== want) begin
      fails++;
      if (fails <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_motor();
      motor_status_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (motor_status_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: result with no request outstanding", $time);
        end else begin
          due_status = motor_status_q.pop_front();
          check_field("coil_pattern", 32'(rsp_mon_i.data.coil_pattern),
                      32'(due_status.coil_pattern));
          check_field("motor_mode", 32'(rsp_mon_i.data.motor_mode),
                      32'(due_status.motor_mode));
          check_field("running_flag", 32'(rsp_mon_i.data.running_flag),
                      32'(due_status.running_flag));
          check_field("status", 32'(rsp_mon_i.data.status), 32'(due_status.status));
          check_field("steps_done", rsp_mon_i.data.steps_done, due_status.steps_done);
          check_field("learned_steps", rsp_mon_i.data.learned_steps,
                      due_status.learned_steps);
        end
      end
      if (req_mon_i.valid && req_mon_i.ready)
        motor_status_q.push_back(next_motor_status(req_mon_i.data));
      fail_count_o <= fails;
      pending_o    <= motor_status_q.size();
    end
  end

endmodule

// File: test/stepper_travel_learning_controller_top_test.sv
// Testbench top for the stepper travel learning controller.
// Drives directed and random requests under several idling patterns and gives
// the verdict. Depends on stlc_pkg, stlc_if, the block and stlc_motor_checker.
`timescale 1ns / 1ps

module stepper_travel_learning_controller_top_test;
  import stlc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 140;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam logic [1:0] LVL_BOTH    = 2'b00;
  localparam logic [1:0] LVL_SECOND  = 2'b01;
  localparam logic [1:0] LVL_FIRST   = 2'b10;
  localparam logic [1:0] LVL_OPEN    = 2'b11;
  localparam logic [3:0] CMD_BAD_TOP = 4'd15;
  localparam logic [9:0] PCT_TOP     = 10'd1023;
  localparam logic [9:0] PCT_HALF    = 10'd50;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_token  = 0;
  int sent_count  = 0;
  int cycle_count = 0;
  int fail_count;
  int pending;

  stlc_in_if  req_ch ();
  stlc_out_if rsp_ch ();

  stepper_travel_learning_controller_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  stlc_motor_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon_i    (req_ch),
    .rsp_mon_i    (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stepper_travel_learning_controller_top_test: done, errors");
      $finish;
    end
  end

  initial begin : result_sink
    int hold_left;
    int tokens_seen;
    hold_left   = 0;
    tokens_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != tokens_seen) begin
        tokens_seen = hold_token;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic in_item_t make_req(input logic [1:0] act, input logic [1:0] lvl,
                                        input logic [3:0] cmd, input logic [9:0] pct);
    in_item_t req;
    req.action        = act;
    req.button_levels = lvl;
    req.command_code  = cmd;
    req.percent_value = pct;
    return req;
  endfunction

  function automatic logic [1:0] any_levels();
    return 2'($urandom_range(3));
  endfunction

  function automatic logic [3:0] any_cmd();
    return 4'($urandom_range(15));
  endfunction

  function automatic logic [9:0] any_pct();
    return 10'($urandom_range(1023));
  endfunction

  task automatic offer(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= req;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    if (req.action != ACT_NONE) sent_count++;
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic tick_run(input int count);
    repeat (count) offer(make_req(ACT_TICK, any_levels(), any_cmd(), any_pct()));
  endtask

  task automatic learn_cycle();
    logic [1:0] start_lvl;
    logic [1:0] stop_lvl;
    logic [3:0] cmd;
    logic [9:0] pct;
    case ($urandom_range(2))
      0: start_lvl = LVL_FIRST;
      1: start_lvl = LVL_SECOND;
      default: start_lvl = LVL_BOTH;
    endcase
    if (start_lvl == LVL_SECOND) stop_lvl = $urandom_range(1) ? LVL_FIRST : LVL_BOTH;
    else stop_lvl = LVL_SECOND;
    offer(make_req(ACT_CMD, any_levels(), CMD_STOP, any_pct()));
    offer(make_req(ACT_BUTTON, start_lvl, any_cmd(), any_pct()));
    tick_run($urandom_range(25));
    if ($urandom_range(3) == 0) offer(make_req(ACT_BUTTON, start_lvl, any_cmd(), any_pct()));
    offer(make_req(ACT_BUTTON, stop_lvl, any_cmd(), any_pct()));
    cmd = 4'($urandom_range(CMD_SWEEP, CMD_FORWARD));
    pct = ($urandom_range(7) == 0) ? 10'($urandom_range(1023, 101)) : 10'($urandom_range(100));
    offer(make_req(ACT_CMD, any_levels(), cmd, pct));
    tick_run($urandom_range(30, 2));
  endtask

  task automatic travel_move();
    logic [3:0] cmd;
    logic [9:0] pct;
    cmd = $urandom_range(1) ? CMD_FORWARD : CMD_REVERSE;
    pct = ($urandom_range(3) == 0) ? any_pct() : 10'($urandom_range(100));
    offer(make_req(ACT_CMD, any_levels(), cmd, pct));
    tick_run($urandom_range(30, 1));
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
    int goal;
    bit held;
    idle_pct  = send_pct;
    stall_pct = recv_pct;
    goal      = sent_count + PHASE_ITEMS;
    held      = 1'b0;
    while (sent_count < goal) begin
      if (with_hold && !held && sent_count >= goal - PHASE_ITEMS / 2) begin
        hold_token++;
        held = 1'b1;
      end
      case ($urandom_range(9))
        0, 1, 2: learn_cycle();
        3, 4:    travel_move();
        5: begin
          offer(make_req(ACT_CMD, any_levels(), CMD_SWEEP, any_pct()));
          tick_run($urandom_range(20, 1));
        end
        6: offer(make_req(ACT_CMD, any_levels(), any_cmd(), any_pct()));
        default:
          repeat ($urandom_range(4, 1))
            offer(make_req(2'($urandom_range(3)), any_levels(), any_cmd(), any_pct()));
      endcase
    end
    settle();
  endtask

  task automatic directed_sequence();
    offer(make_req(ACT_TICK, LVL_OPEN, CMD_STOP, '0));
    offer(make_req(ACT_NONE, LVL_OPEN, CMD_BAD_TOP, PCT_TOP));
    // Zero percent of the travel still gives a single step.
    offer(make_req(ACT_CMD, LVL_BOTH, CMD_FORWARD, '0));
    offer(make_req(ACT_TICK, LVL_OPEN, CMD_STOP, '0));
    offer(make_req(ACT_TICK, LVL_OPEN, CMD_STOP, '0));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_REVERSE, PCT_TOP));
    offer(make_req(ACT_TICK, LVL_BOTH, CMD_STOP, '0));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_STOP, '0));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_BAD_TOP, PCT_TOP));
    offer(make_req(ACT_BUTTON, LVL_OPEN, CMD_STOP, '0));
    offer(make_req(ACT_BUTTON, LVL_FIRST, CMD_STOP, '0));
    offer(make_req(ACT_TICK, LVL_OPEN, CMD_STOP, '0));
    offer(make_req(ACT_BUTTON, LVL_FIRST, CMD_STOP, '0));
    // The other button stops the run and learns the travel.
    offer(make_req(ACT_BUTTON, LVL_SECOND, CMD_STOP, '0));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_STOP, PCT_FULL));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_FORWARD, PCT_FULL + 10'd1));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_SWEEP, '0));
    offer(make_req(ACT_TICK, LVL_BOTH, CMD_STOP, '0));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_SWEEP, PCT_FULL));
    offer(make_req(ACT_TICK, LVL_FIRST, CMD_STOP, '0));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_FORWARD, PCT_HALF));
    offer(make_req(ACT_TICK, LVL_OPEN, CMD_STOP, '0));
    // Both pressed while running counts as the first button.
    offer(make_req(ACT_BUTTON, LVL_BOTH, CMD_STOP, '0));
    offer(make_req(ACT_CMD, LVL_OPEN, CMD_REVERSE, PCT_FULL));
    offer(make_req(ACT_TICK, LVL_OPEN, CMD_STOP, '0));
  endtask

  initial begin : request_source
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_sequence();
    settle();
    run_phase(0, 0, 1'b1);
    run_phase(48, 0, 1'b0);
    run_phase(0, 48, 1'b0);
    run_phase(21, 21, 1'b0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("stepper_travel_learning_controller_top_test: done, clean");
    end else begin
      $display("stepper_travel_learning_controller_top_test: done, errors");
    end
    $finish;
  end

endmodule
